// ----- rtl/mswdt_pkg.sv -----
package mswdt_pkg;

    localparam int TASK_W      = 22;
    localparam int AGE_W       = 16;
    localparam int CLASS_W     = 2;
    localparam int MODE_W      = 3;
    localparam int OUT_IDX_W   = 4;
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS);

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam logic [MODE_W-1:0] MODE_REGISTER = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET_AGE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TICK     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SCAN     = 3'd4;

    typedef enum logic [2:0] {
        OP_REG  = 3'd0,
        OP_REM  = 3'd1,
        OP_SET  = 3'd2,
        OP_TICK = 3'd3,
        OP_SCAN = 3'd4,
        OP_NOP  = 3'd5
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [TASK_W-1:0]  task_id;
        logic [AGE_W-1:0]   limit;
        logic [AGE_W-1:0]   new_age;
        logic [CLASS_W-1:0] task_class;
    } cmd_t;

    typedef struct packed {
        logic [TASK_W-1:0]  task_id;
        logic [AGE_W-1:0]   age;
        logic [AGE_W-1:0]   limit;
        logic [CLASS_W-1:0] cls;
    } entry_t;

    typedef struct packed {
        logic                 ok;
        logic [OUT_IDX_W-1:0] idx;
        logic [TASK_W-1:0]    task_id;
        logic [CLASS_W-1:0]   cls;
        logic                 restart;
    } res_t;

endpackage

// ----- rtl/multi_slot_watchdog_table_core.sv -----
// channel  | direction | ports                                                   | handshake
// ---------+-----------+---------------------------------------------------------+----------
// request  | in        | s_mode s_task_id s_limit s_new_age s_task_class         | s_valid/s_ready
// result   | out       | m_done_ok m_slot_index m_expired_id m_expired_class ... | m_valid/m_ready
//
// A request that walks every slot (tick, scan, no match) passes the walker in order: it is
// taken, slot 0 is fetched, the slots are decided in turn and the final item is loaded. Register,
// remove and set age stop at the first match. Requests pass the request register and queue first.
// Reset (aresetn low, synchronous) marks every slot free at once; no clearing pass.
// A two-entry queue lets requests be taken while the walker waits on m_ready; a scan stalls
// when a second expiry meets a full result register, and every final item waits for it too.
module multi_slot_watchdog_table_core #(
    parameter int SLOTS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mswdt_pkg::MODE_W-1:0]      s_mode,
    input  logic [mswdt_pkg::TASK_W-1:0]      s_task_id,
    input  logic [mswdt_pkg::AGE_W-1:0]       s_limit,
    input  logic [mswdt_pkg::AGE_W-1:0]       s_new_age,
    input  logic [mswdt_pkg::CLASS_W-1:0]     s_task_class,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_done_ok,
    output logic [mswdt_pkg::OUT_IDX_W-1:0]   m_slot_index,
    output logic [mswdt_pkg::TASK_W-1:0]      m_expired_id,
    output logic [mswdt_pkg::CLASS_W-1:0]     m_expired_class,
    output logic                              m_restart,
    output logic                              m_last
);
    import mswdt_pkg::*;

    logic fq_valid;
    logic fq_ready;
    cmd_t fq_cmd;
    logic qb_valid;
    logic qb_ready;
    cmd_t qb_cmd;

    mswdt_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_task_id    (s_task_id),
        .s_limit      (s_limit),
        .s_new_age    (s_new_age),
        .s_task_class (s_task_class),
        .q_valid      (fq_valid),
        .q_ready      (fq_ready),
        .q_cmd        (fq_cmd)
    );

    mswdt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    mswdt_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (qb_valid),
        .cmd_ready       (qb_ready),
        .cmd             (qb_cmd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_done_ok       (m_done_ok),
        .m_slot_index    (m_slot_index),
        .m_expired_id    (m_expired_id),
        .m_expired_class (m_expired_class),
        .m_restart       (m_restart),
        .m_last          (m_last)
    );

endmodule

// ----- rtl/mswdt_front.sv -----
module mswdt_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mswdt_pkg::MODE_W-1:0]      s_mode,
    input  logic [mswdt_pkg::TASK_W-1:0]      s_task_id,
    input  logic [mswdt_pkg::AGE_W-1:0]       s_limit,
    input  logic [mswdt_pkg::AGE_W-1:0]       s_new_age,
    input  logic [mswdt_pkg::CLASS_W-1:0]     s_task_class,
    output logic                              q_valid,
    input  logic                              q_ready,
    output mswdt_pkg::cmd_t                   q_cmd
);
    import mswdt_pkg::*;

    logic f_vld_reg;
    logic f_vld_next;
    cmd_t f_cmd_reg;
    cmd_t dec_cmd;
    logic s_take;

    // set age with id 0 can never match: fold it into a no-op here
    always_comb begin
        dec_cmd.task_id    = s_task_id;
        dec_cmd.limit      = s_limit;
        dec_cmd.new_age    = s_new_age;
        dec_cmd.task_class = s_task_class;
        unique case (s_mode)
            MODE_REGISTER: dec_cmd.op = OP_REG;
            MODE_REMOVE:   dec_cmd.op = OP_REM;
            MODE_SET_AGE:  dec_cmd.op = (s_task_id == '0) ? OP_NOP : OP_SET;
            MODE_TICK:     dec_cmd.op = OP_TICK;
            MODE_SCAN:     dec_cmd.op = OP_SCAN;
            default:       dec_cmd.op = OP_NOP;
        endcase
    end

    assign s_ready = !f_vld_reg || q_ready;
    assign s_take  = s_valid && s_ready;
    assign q_valid = f_vld_reg;
    assign q_cmd   = f_cmd_reg;

    always_comb begin
        if (s_take) begin
            f_vld_next = 1'b1;
        end else if (q_ready) begin
            f_vld_next = 1'b0;
        end else begin
            f_vld_next = f_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg <= 1'b0;
        end else begin
            f_vld_reg <= f_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            f_cmd_reg <= dec_cmd;
        end
    end

endmodule

// ----- rtl/mswdt_queue.sv -----
module mswdt_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  mswdt_pkg::cmd_t in_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output mswdt_pkg::cmd_t out_cmd
);
    import mswdt_pkg::*;

    cmd_t       q_mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = q_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- rtl/mswdt_back.sv -----
module mswdt_back #(
    parameter int SLOTS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  mswdt_pkg::cmd_t                   cmd,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_done_ok,
    output logic [mswdt_pkg::OUT_IDX_W-1:0]   m_slot_index,
    output logic [mswdt_pkg::TASK_W-1:0]      m_expired_id,
    output logic [mswdt_pkg::CLASS_W-1:0]     m_expired_class,
    output logic                              m_restart,
    output logic                              m_last
);
    import mswdt_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [CNT_W-1:0]       issue_cnt_reg, issue_cnt_next;
    logic                   ex_valid_reg, ex_valid_next;
    logic [IDX_W-1:0]       ex_idx_reg, ex_idx_next;
    logic [RES_CNT_W-1:0]   hits_reg, hits_next;
    res_t                   pend_reg, pend_next;
    logic [SLOTS-1:0]       vld_reg, vld_next;

    entry_t                 slot_mem [SLOTS];
    entry_t                 mem_rd_reg;
    logic                   mem_rd_vld_reg;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_idx;
    logic                   mem_we;
    entry_t                 wr_entry;

    logic                   m_valid_reg, m_valid_next;
    res_t                   m_res_reg;
    logic                   m_last_reg;
    logic                   out_free;
    logic                   out_load;
    res_t                   out_res;
    logic                   out_last;

    entry_t                 ent;
    logic                   hit;
    logic                   stop;
    logic                   stall;
    logic                   finish;
    res_t                   hit_res;

    assign out_free = !m_valid_reg || m_ready;
    assign rd_idx   = issue_cnt_reg[IDX_W-1:0];
    // a slot never written since reset reads as free and zero
    assign ent      = mem_rd_vld_reg ? mem_rd_reg : '0;

    // per-slot decision for the slot held in the read register
    always_comb begin
        hit      = 1'b0;
        mem_we   = 1'b0;
        wr_entry = '0;
        unique case (cmd_reg.op)
            OP_REG: begin
                hit              = (ent.task_id == '0);
                mem_we           = hit;
                wr_entry.task_id = cmd_reg.task_id;
                wr_entry.limit   = cmd_reg.limit;
                wr_entry.cls     = cmd_reg.task_class;
            end
            OP_REM: begin
                hit    = (ent.task_id == cmd_reg.task_id);
                mem_we = hit;
            end
            OP_SET: begin
                hit          = (ent.task_id == cmd_reg.task_id);
                mem_we       = hit;
                wr_entry     = ent;
                wr_entry.age = cmd_reg.new_age;
            end
            OP_TICK: begin
                mem_we       = (ent.task_id != '0);
                wr_entry     = ent;
                wr_entry.age = (ent.age == AGE_MAX) ? ent.age : ent.age + AGE_W'(1);
            end
            OP_SCAN: begin
                hit    = (ent.task_id > TASK_W'(1)) && (ent.age > ent.limit)
                         && (ent.cls != '0);
                mem_we = hit;
            end
            default: begin
                hit = 1'b0;
            end
        endcase
        mem_we = mem_we && ex_valid_reg;
    end

    always_comb begin
        hit_res.ok      = 1'b1;
        hit_res.idx     = OUT_IDX_W'(ex_idx_reg);
        hit_res.task_id = '0;
        hit_res.cls     = '0;
        hit_res.restart = 1'b0;
        if (cmd_reg.op == OP_SCAN) begin
            hit_res.task_id = ent.task_id;
            hit_res.cls     = ent.cls;
            hit_res.restart = ent.cls[1];
        end
    end

    always_comb begin
        if (cmd_reg.op == OP_SCAN) begin
            stop = hit && (hits_reg == RES_CNT_W'(MAX_RESULTS - 1));
        end else begin
            stop = hit && (cmd_reg.op != OP_TICK);
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        issue_cnt_next = issue_cnt_reg;
        ex_valid_next  = ex_valid_reg;
        ex_idx_next    = ex_idx_reg;
        hits_next      = hits_reg;
        pend_next      = pend_reg;
        vld_next       = vld_reg;
        cmd_ready      = 1'b0;
        rd_en          = 1'b0;
        out_load       = 1'b0;
        out_res        = pend_reg;
        out_last       = 1'b1;
        stall          = 1'b0;
        finish         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cmd_next       = cmd;
                    issue_cnt_next = '0;
                    ex_valid_next  = 1'b0;
                    hits_next      = '0;
                    pend_next      = '0;
                    pend_next.ok   = (cmd.op == OP_TICK);
                    state_next     = (cmd.op == OP_NOP) ? ST_FINISH : ST_WALK;
                end
            end
            ST_WALK: begin
                // a new scan hit pushes the previous one out first
                stall = ex_valid_reg && hit && (cmd_reg.op == OP_SCAN)
                        && pend_reg.ok && !out_free;
                if (!stall) begin
                    if (ex_valid_reg) begin
                        if (mem_we) begin
                            vld_next[ex_idx_reg] = 1'b1;
                        end
                        if (hit) begin
                            if (cmd_reg.op == OP_SCAN) begin
                                hits_next = hits_reg + RES_CNT_W'(1);
                                out_load  = pend_reg.ok;
                                out_last  = 1'b0;
                            end
                            pend_next = hit_res;
                        end
                        finish = stop || (ex_idx_reg == LAST_IDX);
                    end
                    if (!finish && (issue_cnt_reg < CNT_W'(SLOTS))) begin
                        rd_en          = 1'b1;
                        ex_valid_next  = 1'b1;
                        ex_idx_next    = rd_idx;
                        issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    end else begin
                        ex_valid_next = 1'b0;
                    end
                    if (finish) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ex_valid_reg <= 1'b0;
            vld_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ex_valid_reg <= ex_valid_next;
            vld_reg      <= vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        issue_cnt_reg <= issue_cnt_next;
        ex_idx_reg    <= ex_idx_next;
        hits_reg      <= hits_next;
        pend_reg      <= pend_next;
        if (out_load) begin
            m_res_reg  <= out_res;
            m_last_reg <= out_last;
        end
    end

    // slot table: one write port at the executing slot, one read port ahead of it
    always_ff @(posedge aclk) begin
        if (mem_we && !stall) begin
            slot_mem[ex_idx_reg] <= wr_entry;
        end
        if (rd_en) begin
            mem_rd_reg     <= slot_mem[rd_idx];
            mem_rd_vld_reg <= vld_reg[rd_idx];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_done_ok       = m_res_reg.ok;
    assign m_slot_index    = m_res_reg.idx;
    assign m_expired_id    = m_res_reg.task_id;
    assign m_expired_class = m_res_reg.cls;
    assign m_restart       = m_res_reg.restart;
    assign m_last          = m_last_reg;

endmodule

// ----- bench/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mswdt_pkg::*;

    localparam int SLOTS            = 16;
    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 7;
    localparam int RANDOM_PER_PHASE = 49;
    localparam int POOL_SIZE        = 12;
    localparam int DRAIN_CYCLES     = 4 * SLOTS;

    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

    localparam logic [CLASS_W-1:0] CLASS_NORMAL  = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_ACCOUNT = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_DEPOSIT = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_BALANCE = 2'd3;

    localparam logic [TASK_W-1:0] ID_ALL_ONES = {TASK_W{1'b1}};

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [TASK_W-1:0]  task_id;
        logic [AGE_W-1:0]   limit;
        logic [AGE_W-1:0]   new_age;
        logic [CLASS_W-1:0] task_class;
    } request_t;

    typedef struct {
        logic                 done_ok;
        logic [OUT_IDX_W-1:0] slot_index;
        logic [TASK_W-1:0]    expired_id;
        logic [CLASS_W-1:0]   expired_class;
        logic                 restart;
        logic                 last;
    } outcome_t;

    typedef struct {
        request_t req;
        bit       typed;
        outcome_t want;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [MODE_W-1:0]    s_mode = '0;
    logic [TASK_W-1:0]    s_task_id = '0;
    logic [AGE_W-1:0]     s_limit = '0;
    logic [AGE_W-1:0]     s_new_age = '0;
    logic [CLASS_W-1:0]   s_task_class = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_done_ok;
    logic [OUT_IDX_W-1:0] m_slot_index;
    logic [TASK_W-1:0]    m_expired_id;
    logic [CLASS_W-1:0]   m_expired_class;
    logic                 m_restart;
    logic                 m_last;

    // mirror of the slot table
    logic [TASK_W-1:0]  mirror_task  [SLOTS];
    logic [AGE_W-1:0]   mirror_age   [SLOTS];
    logic [AGE_W-1:0]   mirror_limit [SLOTS];
    logic [CLASS_W-1:0] mirror_class [SLOTS];

    outcome_t          due_outcomes[$];
    outcome_t          fresh_outcomes[$];
    stim_row_t         directed[$];
    logic [TASK_W-1:0] id_pool[POOL_SIZE];

    int error_count = 0;
    int results_seen = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    multi_slot_watchdog_table_core #(
        .SLOTS(SLOTS)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_task_id      (s_task_id),
        .s_limit        (s_limit),
        .s_new_age      (s_new_age),
        .s_task_class   (s_task_class),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_done_ok      (m_done_ok),
        .m_slot_index   (m_slot_index),
        .m_expired_id   (m_expired_id),
        .m_expired_class(m_expired_class),
        .m_restart      (m_restart),
        .m_last         (m_last)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic outcome_t make_outcome(bit ok, int idx, logic [TASK_W-1:0] id,
                                              logic [CLASS_W-1:0] cls, bit rst, bit lst);
        outcome_t o;
        o.done_ok       = ok;
        o.slot_index    = OUT_IDX_W'(idx);
        o.expired_id    = id;
        o.expired_class = cls;
        o.restart       = rst;
        o.last          = lst;
        return o;
    endfunction

    function automatic stim_row_t stim_row(logic [MODE_W-1:0] mode, logic [TASK_W-1:0] id,
                                           logic [AGE_W-1:0] lim, logic [AGE_W-1:0] age,
                                           logic [CLASS_W-1:0] cls, bit typed, bit ok,
                                           int idx);
        stim_row_t row;
        row.req.mode       = mode;
        row.req.task_id    = id;
        row.req.limit      = lim;
        row.req.new_age    = age;
        row.req.task_class = cls;
        row.typed          = typed;
        row.want           = make_outcome(ok, idx, '0, CLASS_NORMAL, 1'b0, 1'b1);
        return row;
    endfunction

    task automatic free_slot(input int s);
        mirror_task[s]  = '0;
        mirror_age[s]   = '0;
        mirror_limit[s] = '0;
        mirror_class[s] = CLASS_NORMAL;
    endtask

    // updates the mirror and leaves the outcomes of one request in fresh_outcomes
    task automatic watchdog_predict(input request_t r);
        bit hit;
        int n;
        int s;
        hit = 1'b0;
        n = 0;
        fresh_outcomes.delete();
        case (r.mode)
            MODE_REGISTER: begin
                for (s = 0; s < SLOTS; s++) begin
                    if (!hit && mirror_task[s] == '0) begin
                        // id 0 fills limit and class but leaves the slot free
                        mirror_task[s]  = r.task_id;
                        mirror_age[s]   = '0;
                        mirror_limit[s] = r.limit;
                        mirror_class[s] = r.task_class;
                        fresh_outcomes.push_back(
                            make_outcome(1'b1, s, '0, CLASS_NORMAL, 1'b0, 1'b1));
                        hit = 1'b1;
                    end
                end
            end
            MODE_REMOVE: begin
                for (s = 0; s < SLOTS; s++) begin
                    if (!hit && mirror_task[s] == r.task_id) begin
                        free_slot(s);
                        fresh_outcomes.push_back(
                            make_outcome(1'b1, s, '0, CLASS_NORMAL, 1'b0, 1'b1));
                        hit = 1'b1;
                    end
                end
            end
            MODE_SET_AGE: begin
                if (r.task_id != '0) begin
                    for (s = 0; s < SLOTS; s++) begin
                        if (!hit && mirror_task[s] == r.task_id) begin
                            mirror_age[s] = r.new_age;
                            fresh_outcomes.push_back(
                                make_outcome(1'b1, s, '0, CLASS_NORMAL, 1'b0, 1'b1));
                            hit = 1'b1;
                        end
                    end
                end
            end
            MODE_TICK: begin
                for (s = 0; s < SLOTS; s++) begin
                    if (mirror_task[s] != '0 && mirror_age[s] != AGE_MAX)
                        mirror_age[s] = mirror_age[s] + 1'b1;
                end
                fresh_outcomes.push_back(make_outcome(1'b1, 0, '0, CLASS_NORMAL, 1'b0, 1'b1));
                hit = 1'b1;
            end
            MODE_SCAN: begin
                for (s = 0; s < SLOTS; s++) begin
                    if (n < MAX_RESULTS && mirror_task[s] > 1 &&
                        mirror_age[s] > mirror_limit[s] && mirror_class[s] != CLASS_NORMAL) begin
                        fresh_outcomes.push_back(make_outcome(1'b1, s, mirror_task[s],
                            mirror_class[s], mirror_class[s] >= CLASS_DEPOSIT, 1'b0));
                        free_slot(s);
                        n++;
                    end
                end
                if (n > 0) begin
                    fresh_outcomes[n-1].last = 1'b1;
                    hit = 1'b1;
                end
            end
            default: ;
        endcase
        if (!hit)
            fresh_outcomes.push_back(make_outcome(1'b0, 0, '0, CLASS_NORMAL, 1'b0, 1'b1));
    endtask

    task automatic flag_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // called just after a rising edge; returns just after the edge that takes the item
    task automatic send_request(input request_t r, input bit typed, input outcome_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= r.mode;
        s_task_id    <= r.task_id;
        s_limit      <= r.limit;
        s_new_age    <= r.new_age;
        s_task_class <= r.task_class;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        watchdog_predict(r);
        if (typed)
            due_outcomes.push_back(want);
        else
            foreach (fresh_outcomes[k]) due_outcomes.push_back(fresh_outcomes[k]);
        @(posedge aclk);
    endtask

    function automatic request_t random_request();
        request_t r;
        int pick;
        pick = $urandom_range(0, 99);
        r.task_id    = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, POOL_SIZE-1)]
                                                    : TASK_W'($urandom);
        r.limit      = ($urandom_range(0, 99) < 70) ? AGE_W'($urandom_range(0, 4))
                                                    : AGE_W'($urandom);
        case ($urandom_range(0, 3))
            0, 1:    r.new_age = AGE_W'($urandom_range(0, 6));
            2:       r.new_age = AGE_W'($urandom);
            default: r.new_age = AGE_MAX - AGE_W'($urandom_range(0, 1));
        endcase
        r.task_class = CLASS_W'($urandom_range(0, 3));
        if (pick < 25)
            r.mode = MODE_REGISTER;
        else if (pick < 40)
            r.mode = MODE_REMOVE;
        else if (pick < 55)
            r.mode = MODE_SET_AGE;
        else if (pick < 75)
            r.mode = MODE_TICK;
        else if (pick < 90)
            r.mode = MODE_SCAN;
        else begin
            // noise: any mode, any field value
            r.mode    = MODE_W'($urandom_range(0, 7));
            r.task_id = TASK_W'($urandom);
            r.limit   = AGE_W'($urandom);
            r.new_age = AGE_W'($urandom);
        end
        return r;
    endfunction

    always @(negedge aclk) begin
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (due_outcomes.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
                want = due_outcomes.pop_front();
                if (m_done_ok !== want.done_ok)
                    flag_mismatch($sformatf("result %0d done_ok %b, want %b",
                                            results_seen, m_done_ok, want.done_ok));
                if (m_slot_index !== want.slot_index)
                    flag_mismatch($sformatf("result %0d slot_index %0d, want %0d",
                                            results_seen, m_slot_index, want.slot_index));
                if (m_expired_id !== want.expired_id)
                    flag_mismatch($sformatf("result %0d expired_id %h, want %h",
                                            results_seen, m_expired_id, want.expired_id));
                if (m_expired_class !== want.expired_class)
                    flag_mismatch($sformatf("result %0d expired_class %0d, want %0d",
                                            results_seen, m_expired_class, want.expired_class));
                if (m_restart !== want.restart)
                    flag_mismatch($sformatf("result %0d restart %b, want %b",
                                            results_seen, m_restart, want.restart));
                if (m_last !== want.last)
                    flag_mismatch($sformatf("result %0d last %b, want %b",
                                            results_seen, m_last, want.last));
            end
        end
    end

    initial begin
        int idle_by_phase[4];
        int stall_by_phase[4];
        int sent;
        request_t r;
        outcome_t none;
        idle_by_phase  = '{0, 68, 0, 31};
        stall_by_phase = '{0, 0, 68, 31};
        none = make_outcome(1'b0, 0, '0, CLASS_NORMAL, 1'b0, 1'b1);
        for (int s = 0; s < SLOTS; s++) free_slot(s);

        id_pool[0] = '0;
        id_pool[1] = TASK_W'(1);
        id_pool[2] = TASK_W'(2);
        id_pool[3] = ID_ALL_ONES;
        for (int k = 4; k < POOL_SIZE; k++) id_pool[k] = TASK_W'($urandom) | TASK_W'(2);

        // empty table, repairs and id 0 corners
        directed.push_back(stim_row(MODE_SCAN, '0, '0, '0, CLASS_NORMAL, 1'b1, 1'b0, 0));
        directed.push_back(stim_row(MODE_TICK, '0, '0, '0, CLASS_NORMAL, 1'b1, 1'b1, 0));
        directed.push_back(stim_row(MODE_SET_AGE, '0, '0, AGE_MAX, CLASS_NORMAL,
                                    1'b1, 1'b0, 0));
        directed.push_back(stim_row(MODE_REMOVE, '0, '0, '0, CLASS_NORMAL, 1'b1, 1'b1, 0));
        directed.push_back(stim_row(MODE_REGISTER, ID_ALL_ONES, '0, '0, CLASS_BALANCE,
                                    1'b1, 1'b1, 0));
        directed.push_back(stim_row(MODE_REGISTER, TASK_W'(1), '0, '0, CLASS_ACCOUNT,
                                    1'b1, 1'b1, 1));
        directed.push_back(stim_row(MODE_REGISTER, '0, AGE_MAX, '0, CLASS_DEPOSIT,
                                    1'b1, 1'b1, 2));
        directed.push_back(stim_row(MODE_REGISTER, TASK_W'(2), '0, '0, CLASS_NORMAL,
                                    1'b1, 1'b1, 2));
        directed.push_back(stim_row(MODE_REGISTER, TASK_W'(5), AGE_MAX, '0, CLASS_DEPOSIT,
                                    1'b1, 1'b1, 3));
        // age saturates at the top and never exceeds a maximal limit
        directed.push_back(stim_row(MODE_SET_AGE, TASK_W'(5), '0, AGE_MAX, CLASS_NORMAL,
                                    1'b1, 1'b1, 3));
        directed.push_back(stim_row(MODE_TICK, '0, '0, '0, CLASS_NORMAL, 1'b1, 1'b1, 0));
        directed.push_back(stim_row(MODE_SCAN, '0, '0, '0, CLASS_NORMAL, 1'b0, 1'b0, 0));
        directed.push_back(stim_row(MODE_REGISTER, TASK_W'(6), AGE_W'(1), '0, CLASS_ACCOUNT,
                                    1'b1, 1'b1, 0));
        directed.push_back(stim_row(MODE_TICK, '0, '0, '0, CLASS_NORMAL, 1'b1, 1'b1, 0));
        directed.push_back(stim_row(MODE_TICK, '0, '0, '0, CLASS_NORMAL, 1'b1, 1'b1, 0));
        directed.push_back(stim_row(MODE_SCAN, '0, '0, '0, CLASS_NORMAL, 1'b0, 1'b0, 0));
        directed.push_back(stim_row(MODE_SET_AGE, TASK_W'(2), '0, AGE_W'(5), CLASS_NORMAL,
                                    1'b1, 1'b1, 2));
        directed.push_back(stim_row(MODE_REMOVE, TASK_W'(5), '0, '0, CLASS_NORMAL,
                                    1'b1, 1'b1, 3));
        directed.push_back(stim_row(MODE_SPARE_A, ID_ALL_ONES, AGE_MAX, AGE_MAX, CLASS_BALANCE,
                                    1'b1, 1'b0, 0));
        directed.push_back(stim_row(MODE_SPARE_B, '0, '0, '0, CLASS_NORMAL, 1'b1, 1'b0, 0));
        directed.push_back(stim_row(MODE_SPARE_C, TASK_W'(6), '0, '0, CLASS_ACCOUNT,
                                    1'b1, 1'b0, 0));
        directed.push_back(stim_row(MODE_REMOVE, TASK_W'('h2AAAAA), '0, '0, CLASS_NORMAL,
                                    1'b1, 1'b0, 0));
        directed.push_back(stim_row(MODE_REGISTER, TASK_W'('h155555), AGE_W'('h5555),
                                    AGE_W'('hAAAA), CLASS_ACCOUNT, 1'b1, 1'b1, 0));
        // id 1 and normal class are past their deadline but never reported
        directed.push_back(stim_row(MODE_SCAN, '0, '0, '0, CLASS_NORMAL, 1'b1, 1'b0, 0));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_by_phase[p];
            stall_pct     = stall_by_phase[p];
            if (p == 0)
                foreach (directed[k]) send_request(directed[k].req, directed[k].typed,
                                                   directed[k].want);
            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                if ($urandom_range(0, 24) == 0) begin
                    // fill the table past full with expiring tasks, then age and scan
                    repeat (SLOTS + 1) begin
                        r.mode       = MODE_REGISTER;
                        r.task_id    = id_pool[$urandom_range(2, POOL_SIZE-1)];
                        r.limit      = '0;
                        r.new_age    = AGE_W'($urandom);
                        r.task_class = CLASS_W'($urandom_range(1, 3));
                        send_request(r, 1'b0, none);
                    end
                    r.mode = MODE_TICK;
                    send_request(r, 1'b0, none);
                    r.mode = MODE_SCAN;
                    send_request(r, 1'b0, none);
                    sent += SLOTS + 3;
                end else begin
                    send_request(random_request(), 1'b0, none);
                    sent++;
                end
            end
        end
        s_valid <= 1'b0;

        while (due_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
